// ===== sv/awfs_pkg.sv =====
// Shared constants and types for the animated WebP frame splitter.
// No dependencies; every other file of the block refers to this package.
package awfs_pkg;

   // Field widths.
   localparam int unsigned DUR_W         = 24;
   localparam int unsigned OUT_TIME_W    = 48;
   localparam int unsigned SIZE_W        = 32;
   localparam int unsigned HIST_W        = 64;

   // Default width of the running frame time.
   localparam int unsigned TIME_BITS_DEF = 48;

   // Chunk walking constants.
   localparam logic [SIZE_W-1:0] HDR_BYTES         = 32'd8;
   localparam logic [SIZE_W-1:0] RIFF_FORM_BYTES   = 32'd4;
   localparam logic [SIZE_W-1:0] DUR_CAPTURE_COUNT = 32'd16;
   localparam logic [31:0]       TAG_ANMF          = 32'h414E_4D46;
   localparam logic [31:0]       TAG_RIFF          = 32'h5249_4646;

   // Reset value of the default duration register.
   localparam logic [DUR_W-1:0] DEFAULT_DURATION_RST = 24'd100;

   // Input commands.
   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // Events from the chunk walker to the frame timer for one step.
   typedef struct packed {
      logic             riff_reset;   // first header was RIFF
      logic             anmf_header;  // ANMF header after the first header
      logic             capture;      // frame duration bytes complete
      logic [DUR_W-1:0] duration;     // captured duration
      logic             flush;        // end of stream command
   } walk_event_type;

   // One result item.
   typedef struct packed {
      logic                  frame_end;
      logic [DUR_W-1:0]      frame_duration;
      logic [OUT_TIME_W-1:0] frame_time;
      logic                  key_flag;
   } frame_result_type;

endpackage

// ===== sv/awfs_ifs.sv =====
// Valid/ready channel interfaces for the animated WebP frame splitter.
// Depends on awfs_pkg for field widths.

// Input channel: one command with its data byte per transfer.
interface awfs_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// Result channel: one frame report per transfer.
interface awfs_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           frame_end;
   logic [awfs_pkg::DUR_W-1:0]     frame_duration;
   logic [awfs_pkg::OUT_TIME_W-1:0] frame_time;
   logic                           key_flag;

   modport source (output valid, output frame_end, output frame_duration,
                   output frame_time, output key_flag, input ready);
   modport sink   (input valid, input frame_end, input frame_duration,
                   input frame_time, input key_flag, output ready);
endinterface

// Configuration write channel for the default duration register.
interface awfs_csr_if;
   logic                       valid;
   logic                       ready;
   logic [awfs_pkg::DUR_W-1:0] default_duration;

   modport source (output valid, output default_duration, input ready);
   modport sink   (input valid, input default_duration, output ready);
endinterface

// ===== sv/awfs_walker.sv =====
// RIFF chunk walker: byte history, header parsing and body skipping.
// Depends on awfs_pkg for constants and the walk_event_type struct.
module awfs_walker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic                     flush_en,
   input  logic [7:0]               data_byte,
   output awfs_pkg::walk_event_type evt
);

   localparam logic [1:0] WALK_IDLE     = 2'd0;
   localparam logic [1:0] WALK_FIRST_HDR = 2'd1;
   localparam logic [1:0] WALK_BODY     = 2'd2;
   localparam logic [1:0] WALK_HDR      = 2'd3;

   logic [awfs_pkg::HIST_W-1:0] hist_ff, hist_in, hist_next;
   logic [1:0]                  mode_ff, mode_in, mode_eff;
   logic [awfs_pkg::SIZE_W-1:0] count_ff, count_in, count_inc;
   logic [awfs_pkg::SIZE_W-1:0] target_ff, target_in, target_eff;
   logic                        anim_ff, anim_in;
   logic [31:0]                 hdr_tag;
   logic [awfs_pkg::SIZE_W-1:0] size_raw, size_pad;
   logic                        in_header, count_done;

   // Shift the new byte in and decode the header view of the history.
   always_comb begin
      hist_next  = {hist_ff[awfs_pkg::HIST_W-9:0], data_byte};
      count_inc  = count_ff + awfs_pkg::SIZE_W'(1);
      mode_eff   = (mode_ff == WALK_IDLE) ? WALK_FIRST_HDR : mode_ff;
      target_eff = (mode_ff == WALK_IDLE) ? awfs_pkg::HDR_BYTES : target_ff;
      hdr_tag    = hist_next[63:32];
      size_raw   = {hist_next[7:0], hist_next[15:8], hist_next[23:16], hist_next[31:24]};
      size_pad   = (size_raw[0] && (size_raw != '1)) ? size_raw + awfs_pkg::SIZE_W'(1)
                                                     : size_raw;
      in_header  = (mode_eff == WALK_FIRST_HDR) || (mode_eff == WALK_HDR);
      count_done = (count_inc >= target_eff);
   end

   // Next walker state and the events of this step.
   always_comb begin
      hist_in   = hist_ff;
      mode_in   = mode_ff;
      count_in  = count_ff;
      target_in = target_ff;
      anim_in   = anim_ff;
      evt       = '0;
      evt.flush = flush_en;
      evt.duration = {hist_next[15:8], hist_next[23:16], hist_next[31:24]};
      if (step_en) begin
         hist_in   = hist_next;
         count_in  = count_inc;
         mode_in   = mode_eff;
         target_in = target_eff;
         if (in_header) begin
            if (count_done) begin
               count_in = '0;
               if ((mode_eff == WALK_FIRST_HDR) && (hdr_tag == awfs_pkg::TAG_RIFF)) begin
                  // Step into the RIFF body past its form tag only.
                  anim_in        = 1'b0;
                  evt.riff_reset = 1'b1;
                  target_in      = awfs_pkg::RIFF_FORM_BYTES;
                  mode_in        = WALK_BODY;
               end else begin
                  anim_in         = (hdr_tag == awfs_pkg::TAG_ANMF);
                  evt.anmf_header = (mode_eff == WALK_HDR) &&
                                    (hdr_tag == awfs_pkg::TAG_ANMF);
                  if (size_pad == '0) begin
                     target_in = awfs_pkg::HDR_BYTES;
                     mode_in   = WALK_HDR;
                  end else begin
                     target_in = size_pad;
                     mode_in   = WALK_BODY;
                  end
               end
            end
         end else begin
            // Chunk body: grab the frame duration, then wait for the end.
            evt.capture = anim_ff && (count_inc == awfs_pkg::DUR_CAPTURE_COUNT);
            if (count_done) begin
               count_in  = '0;
               target_in = awfs_pkg::HDR_BYTES;
               mode_in   = WALK_HDR;
            end
         end
      end
   end

   // Walker state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         mode_ff   <= WALK_IDLE;
         count_ff  <= '0;
         target_ff <= '0;
         anim_ff   <= 1'b0;
      end else begin
         hist_ff   <= hist_in;
         mode_ff   <= mode_in;
         count_ff  <= count_in;
         target_ff <= target_in;
         anim_ff   <= anim_in;
      end
   end

endmodule

// ===== sv/awfs_timer.sv =====
// Frame timer: held duration, running presentation time and frame reports.
// Depends on awfs_pkg for widths and the event and result structs.
module awfs_timer #(
   parameter int unsigned TIME_BITS = awfs_pkg::TIME_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  awfs_pkg::walk_event_type   evt,
   input  logic [awfs_pkg::DUR_W-1:0] default_duration,
   output awfs_pkg::frame_result_type result
);

   logic                       seen_ff, seen_in;
   logic [awfs_pkg::DUR_W-1:0] held_dur_ff, held_dur_in;
   logic [TIME_BITS-1:0]       held_time_ff, held_time_in;
   logic [TIME_BITS-1:0]       next_time_ff, next_time_in;
   logic                       finish;
   logic [awfs_pkg::DUR_W-1:0] report_dur;
   logic [TIME_BITS:0]         time_sum;
   logic [TIME_BITS-1:0]       time_sat;

   // A frame ends on a flush or a later ANMF header once a frame is open.
   always_comb begin
      finish     = seen_ff && (evt.flush || evt.anmf_header);
      report_dur = (held_dur_ff == '0) ? default_duration : held_dur_ff;
      time_sum   = {1'b0, held_time_ff} + (TIME_BITS + 1)'(report_dur);
      time_sat   = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];
   end

   // Next timer state.
   always_comb begin
      seen_in      = seen_ff;
      held_dur_in  = held_dur_ff;
      held_time_in = held_time_ff;
      next_time_in = next_time_ff;
      if (evt.riff_reset) begin
         seen_in = 1'b0;
      end else if (evt.anmf_header) begin
         seen_in = 1'b1;
      end else if (evt.flush) begin
         seen_in = 1'b0;
      end
      if (evt.capture) begin
         held_dur_in  = evt.duration;
         held_time_in = next_time_ff;
      end else if (finish) begin
         held_dur_in = '0;
      end
      if (finish) begin
         next_time_in = time_sat;
      end
   end

   // Report fields are zero unless a frame finished.
   always_comb begin
      result                = '0;
      result.frame_end      = finish;
      if (finish) begin
         result.frame_duration = report_dur;
         result.frame_time     = awfs_pkg::OUT_TIME_W'(held_time_ff);
         result.key_flag       = (held_time_ff == '0);
      end
   end

   // Timer state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         held_dur_ff  <= '0;
         held_time_ff <= '0;
         next_time_ff <= '0;
      end else begin
         seen_ff      <= seen_in;
         held_dur_ff  <= held_dur_in;
         held_time_ff <= held_time_in;
         next_time_ff <= next_time_in;
      end
   end

endmodule

// ===== sv/animated_webp_frame_splitter.sv =====
// Animated WebP frame splitter, top level. One result per input transfer.
// Path: a transfer is held in the input register, processed when the result register
// is free, and its result is registered in the result register that drives rsp_chan.
// Throughput: one byte or command per cycle while rsp_chan is ready; both registers move together.
// Reset: synchronous, clears the walker and timer state and sets the
// default duration to 100. Depends on awfs_pkg, awfs_ifs, awfs_walker, awfs_timer.
module animated_webp_frame_splitter #(
   parameter int unsigned TIME_BITS = awfs_pkg::TIME_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   awfs_req_if.sink   req_chan,
   awfs_rsp_if.source rsp_chan,
   awfs_csr_if.sink   csr_chan
);

   logic                       in_valid_ff, in_valid_in;
   logic                       in_cmd_ff;
   logic [7:0]                 in_byte_ff;
   logic                       out_valid_ff, out_valid_in;
   awfs_pkg::frame_result_type out_ff;
   awfs_pkg::frame_result_type result;
   awfs_pkg::walk_event_type   evt;
   logic [awfs_pkg::DUR_W-1:0] default_duration_ff;
   logic                       advance;
   logic                       req_take;

   // Handshake: the held item moves on when the result register is free.
   always_comb begin
      advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
      req_chan.ready = !in_valid_ff || advance;
      req_take       = req_chan.valid && req_chan.ready;
      in_valid_in    = req_take || (in_valid_ff && !advance);
      out_valid_in   = advance || (out_valid_ff && !rsp_chan.ready);
      csr_chan.ready = 1'b1;
   end

   // Result channel outputs.
   always_comb begin
      rsp_chan.valid          = out_valid_ff;
      rsp_chan.frame_end      = out_ff.frame_end;
      rsp_chan.frame_duration = out_ff.frame_duration;
      rsp_chan.frame_time     = out_ff.frame_time;
      rsp_chan.key_flag       = out_ff.key_flag;
   end

   awfs_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance && (in_cmd_ff == awfs_pkg::CMD_DATA)),
      .flush_en  (advance && (in_cmd_ff == awfs_pkg::CMD_FLUSH)),
      .data_byte (in_byte_ff),
      .evt       (evt)
   );

   awfs_timer #(
      .TIME_BITS (TIME_BITS)
   ) u_timer (
      .clock            (clock),
      .reset            (reset),
      .evt              (evt),
      .default_duration (default_duration_ff),
      .result           (result)
   );

   // Valid flags and the configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         default_duration_ff <= awfs_pkg::DEFAULT_DURATION_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            default_duration_ff <= csr_chan.default_duration;
         end
      end
   end

   // Payload registers for the input item and the result.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_chan.command;
         in_byte_ff <= req_chan.data_byte;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

endmodule
